// File: rtl/ctpt_pkg.sv
// Package with the shared constants, codes and control types of the cubic trajectory block.
`default_nettype none

package ctpt_pkg;

    localparam int MAX_STEPS  = 65535;
    localparam int FRAC_BITS  = 16;
    localparam int RECIP_BITS = 24;

    localparam int POS_W   = 32;
    localparam int ANGLE_W = 31;
    localparam int DIFF_W  = POS_W + 1;
    localparam int STEPS_W = 16;
    localparam int COUNT_W = STEPS_W + 1;
    localparam int RECIP_W = RECIP_BITS + 1;
    localparam int U_W     = RECIP_BITS + 3;
    localparam int MUL_A_W = DIFF_W + 1;
    localparam int MUL_B_W = U_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int DIV_W     = DIFF_W;
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [ANGLE_W-1:0] STEP_ANGLE_RESET = ANGLE_W'(64'd1 << FRAC_BITS);
    localparam logic [RECIP_W-1:0] RECIP_RESET      = RECIP_W'(64'd1 << RECIP_BITS);
    localparam logic [DIV_W-1:0]   RECIP_ONE        = DIV_W'(64'd1 << RECIP_BITS);
    localparam logic [STEPS_W-1:0] STEPS_MAX        = STEPS_W'(MAX_STEPS);
    localparam logic [COUNT_W-1:0] COUNT_RESET      = COUNT_W'(2);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_INIT   = DIV_CNT_W'(DIV_STEPS);

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } ctpt_opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_N_START,
        ST_N_WAIT,
        ST_R_START,
        ST_R_WAIT,
        ST_T_MUL,
        ST_T2_MUL,
        ST_T3_MUL,
        ST_U_CALC,
        ST_ACC_MUL,
        ST_SUM,
        ST_OUT
    } ctpt_state_t;

    typedef enum logic [1:0] {
        MUL_T,
        MUL_T2,
        MUL_T3,
        MUL_ACC
    } ctpt_mul_op_t;

    typedef struct packed {
        logic         load_move;
        logic         div_start;
        logic         div_recip;
        logic         take_n;
        logic         take_r;
        logic         mul_go;
        ctpt_mul_op_t mul_op;
        logic         take_u;
        logic         take_sum;
        logic         hold_goal;
        logic         out_load;
    } ctpt_cmd_t;

    typedef struct packed {
        logic div_done;
        logic zero_angle;
        logic move_active;
        logic final_step;
    } ctpt_status_t;

endpackage

`default_nettype wire

// File: rtl/ctpt_in_if.sv
// Input channel interface: valid, ready and the fields of one input item.
`default_nettype none

interface ctpt_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [ctpt_pkg::POS_W-1:0]   start_position;
    logic signed [ctpt_pkg::POS_W-1:0]   goal_position;

    modport source (
        output valid,
        input  ready,
        output opcode,
        output start_position,
        output goal_position
    );

    modport sink (
        input  valid,
        output ready,
        input  opcode,
        input  start_position,
        input  goal_position
    );
endinterface

`default_nettype wire

// File: rtl/ctpt_out_if.sv
// Output channel interface: valid, ready and the fields of one result item.
`default_nettype none

interface ctpt_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [ctpt_pkg::POS_W-1:0]   setpoint;
    logic                                complete;

    modport source (
        output valid,
        input  ready,
        output setpoint,
        output complete
    );

    modport sink (
        input  valid,
        output ready,
        input  setpoint,
        input  complete
    );
endinterface

`default_nettype wire

// File: rtl/ctpt_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module ctpt_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [ctpt_pkg::DIV_W-1:0]       dividend,
    input  wire logic [ctpt_pkg::ANGLE_W-1:0]     divisor,
    output logic      [ctpt_pkg::DIV_W-1:0]       quotient,
    output logic                                  done
);

    logic [ctpt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [ctpt_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [ctpt_pkg::ANGLE_W-1:0]   rem_reg, rem_next;
    logic [ctpt_pkg::ANGLE_W-1:0]   dvs_reg, dvs_next;

    logic [ctpt_pkg::ANGLE_W:0]     shifted;
    logic [ctpt_pkg::ANGLE_W:0]     trial;
    logic                           fits;
    logic                           busy;

    assign busy    = (cnt_reg != '0);
    assign shifted = {rem_reg, quo_reg[ctpt_pkg::DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = ctpt_pkg::DIV_CNT_INIT;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (busy)
        begin
            cnt_next  = cnt_reg - 1'b1;
            quo_next  = {quo_reg[ctpt_pkg::DIV_W-2:0], fits};
            rem_next  = fits ? trial[ctpt_pkg::ANGLE_W-1:0] : shifted[ctpt_pkg::ANGLE_W-1:0];
            done_next = (cnt_reg == ctpt_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("divider started while a division is running");
`endif

endmodule

`default_nettype wire

// File: rtl/ctpt_datapath.sv
// Datapath: move state, step-angle register, shared multiplier, divider and output payload.
`default_nettype none

module ctpt_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic        [ctpt_pkg::ANGLE_W-1:0] cfg_write_data,
    input  wire logic signed [ctpt_pkg::POS_W-1:0]   start_position,
    input  wire logic signed [ctpt_pkg::POS_W-1:0]   goal_position,
    input  wire ctpt_pkg::ctpt_cmd_t                 cmd,
    output ctpt_pkg::ctpt_status_t                   status,
    output logic signed      [ctpt_pkg::POS_W-1:0]   setpoint,
    output logic                                     complete
);

    // Architectural move state.
    logic        [ctpt_pkg::ANGLE_W-1:0] angle_reg;
    logic signed [ctpt_pkg::DIFF_W-1:0]  diff_reg;
    logic        [ctpt_pkg::DIFF_W-1:0]  mag_reg;
    logic signed [ctpt_pkg::POS_W-1:0]   start_hold_reg;
    logic signed [ctpt_pkg::POS_W-1:0]   goal_hold_reg;
    logic        [ctpt_pkg::STEPS_W-1:0] total_steps_reg, total_steps_next;
    logic        [ctpt_pkg::RECIP_W-1:0] step_recip_reg;
    logic        [ctpt_pkg::COUNT_W-1:0] step_count_reg;
    logic signed [ctpt_pkg::POS_W-1:0]   held_reg, held_next;

    // Evaluation scratch registers.
    logic signed [ctpt_pkg::PROD_W-1:0]  prod_reg;
    logic        [ctpt_pkg::RECIP_W-1:0] t_reg;
    logic        [ctpt_pkg::RECIP_W-1:0] t2_reg;
    logic signed [ctpt_pkg::U_W-1:0]     u_reg;
    logic signed [ctpt_pkg::POS_W-1:0]   setpoint_reg;
    logic                                complete_reg;

    logic signed [ctpt_pkg::DIFF_W-1:0]  diff_in;
    logic        [ctpt_pkg::DIFF_W-1:0]  mag_in;

    logic        [ctpt_pkg::DIV_W-1:0]   div_dividend;
    logic        [ctpt_pkg::ANGLE_W-1:0] div_divisor;
    logic        [ctpt_pkg::DIV_W-1:0]   div_quotient;
    logic                                div_done;

    logic signed [ctpt_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ctpt_pkg::MUL_B_W-1:0] mul_b;
    logic signed [ctpt_pkg::PROD_W-1:0]  prod_full;
    logic        [ctpt_pkg::RECIP_W-1:0] prod_low;
    logic        [ctpt_pkg::RECIP_W-1:0] prod_mid;

    logic signed [ctpt_pkg::U_W:0]       u_wide;
    logic signed [ctpt_pkg::PROD_W-ctpt_pkg::RECIP_BITS-1:0] acc_floor;
    logic signed [ctpt_pkg::PROD_W-ctpt_pkg::RECIP_BITS:0]   sum_wide;
    logic signed [ctpt_pkg::POS_W-1:0]   sum_sat;
    logic                                zero_angle;

    assign diff_in = $signed({start_position[ctpt_pkg::POS_W-1], start_position})
                   - $signed({goal_position[ctpt_pkg::POS_W-1], goal_position});
    assign mag_in  = diff_in[ctpt_pkg::DIFF_W-1] ? (ctpt_pkg::DIFF_W'(0) - diff_in) : diff_in;

    assign zero_angle = (angle_reg == '0);

    // Divider operands: the move distance over the step angle, then one over the step count.
    assign div_dividend = cmd.div_recip ? ctpt_pkg::RECIP_ONE : mag_reg;
    assign div_divisor  = cmd.div_recip
                        ? {{(ctpt_pkg::ANGLE_W-ctpt_pkg::STEPS_W){1'b0}}, total_steps_reg}
                        : angle_reg;

    ctpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    always_comb
    begin
        if (zero_angle)
            total_steps_next = ctpt_pkg::STEPS_MAX;
        else if (div_quotient == '0)
            total_steps_next = ctpt_pkg::STEPS_W'(1);
        else if (div_quotient > {{(ctpt_pkg::DIV_W-ctpt_pkg::STEPS_W){1'b0}},
                                 ctpt_pkg::STEPS_MAX})
            total_steps_next = ctpt_pkg::STEPS_MAX;
        else
            total_steps_next = div_quotient[ctpt_pkg::STEPS_W-1:0];
    end

    assign prod_low = prod_reg[ctpt_pkg::RECIP_W-1:0];
    assign prod_mid = prod_reg[ctpt_pkg::RECIP_BITS+ctpt_pkg::RECIP_W-1:ctpt_pkg::RECIP_BITS];

    // One shared signed multiplier; every product lands in prod_reg.
    always_comb
    begin
        case (cmd.mul_op)
            ctpt_pkg::MUL_T:
            begin
                mul_a = $signed({{(ctpt_pkg::MUL_A_W-ctpt_pkg::COUNT_W){1'b0}}, step_count_reg});
                mul_b = $signed({{(ctpt_pkg::MUL_B_W-ctpt_pkg::RECIP_W){1'b0}}, step_recip_reg});
            end
            ctpt_pkg::MUL_T2:
            begin
                mul_a = $signed({{(ctpt_pkg::MUL_A_W-ctpt_pkg::RECIP_W){1'b0}}, prod_low});
                mul_b = $signed({{(ctpt_pkg::MUL_B_W-ctpt_pkg::RECIP_W){1'b0}}, prod_low});
            end
            ctpt_pkg::MUL_T3:
            begin
                mul_a = $signed({{(ctpt_pkg::MUL_A_W-ctpt_pkg::RECIP_W){1'b0}}, prod_mid});
                mul_b = $signed({{(ctpt_pkg::MUL_B_W-ctpt_pkg::RECIP_W){1'b0}}, t_reg});
            end
            ctpt_pkg::MUL_ACC:
            begin
                mul_a = $signed({diff_reg[ctpt_pkg::DIFF_W-1], diff_reg});
                mul_b = $signed({u_reg[ctpt_pkg::U_W-1], u_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // The two cubic terms share the move difference: a*t3 + b*t2 = diff*(2*t3 - 3*t2).
    assign u_wide = $signed({2'b00, prod_mid, 1'b0})
                  - $signed({3'b000, t2_reg})
                  - $signed({2'b00, t2_reg, 1'b0});

    assign acc_floor = prod_reg[ctpt_pkg::PROD_W-1:ctpt_pkg::RECIP_BITS];
    assign sum_wide  = $signed({acc_floor[ctpt_pkg::PROD_W-ctpt_pkg::RECIP_BITS-1], acc_floor})
                     + $signed({{(ctpt_pkg::PROD_W-ctpt_pkg::RECIP_BITS-ctpt_pkg::POS_W+1)
                                 {start_hold_reg[ctpt_pkg::POS_W-1]}}, start_hold_reg});

    always_comb
    begin
        if (sum_wide[ctpt_pkg::PROD_W-ctpt_pkg::RECIP_BITS:ctpt_pkg::POS_W-1] == '0
            || sum_wide[ctpt_pkg::PROD_W-ctpt_pkg::RECIP_BITS:ctpt_pkg::POS_W-1] == '1)
            sum_sat = sum_wide[ctpt_pkg::POS_W-1:0];
        else if (sum_wide[ctpt_pkg::PROD_W-ctpt_pkg::RECIP_BITS])
            sum_sat = {1'b1, {(ctpt_pkg::POS_W-1){1'b0}}};
        else
            sum_sat = {1'b0, {(ctpt_pkg::POS_W-1){1'b1}}};
    end

    always_comb
    begin
        held_next = held_reg;
        if (cmd.load_move)
            held_next = start_position;
        else if (cmd.hold_goal)
            held_next = goal_hold_reg;
        else if (cmd.take_sum)
            held_next = sum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg       <= ctpt_pkg::STEP_ANGLE_RESET;
            diff_reg        <= '0;
            mag_reg         <= '0;
            start_hold_reg  <= '0;
            goal_hold_reg   <= '0;
            total_steps_reg <= ctpt_pkg::STEPS_W'(1);
            step_recip_reg  <= ctpt_pkg::RECIP_RESET;
            step_count_reg  <= ctpt_pkg::COUNT_RESET;
            held_reg        <= '0;
        end
        else
        begin
            if (cfg_write_en)
                angle_reg <= cfg_write_data;
            if (cmd.load_move)
            begin
                diff_reg       <= diff_in;
                mag_reg        <= mag_in;
                start_hold_reg <= start_position;
                goal_hold_reg  <= goal_position;
                step_count_reg <= '0;
            end
            else if (cmd.hold_goal || cmd.take_sum)
                step_count_reg <= step_count_reg + 1'b1;
            if (cmd.take_n)
                total_steps_reg <= total_steps_next;
            if (cmd.take_r)
                step_recip_reg <= div_quotient[ctpt_pkg::RECIP_W-1:0];
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
            prod_reg <= prod_full;
        if (cmd.mul_go && cmd.mul_op == ctpt_pkg::MUL_T2)
            t_reg <= prod_low;
        if (cmd.mul_go && cmd.mul_op == ctpt_pkg::MUL_T3)
            t2_reg <= prod_mid;
        if (cmd.take_u)
            u_reg <= u_wide[ctpt_pkg::U_W-1:0];
        if (cmd.out_load)
        begin
            setpoint_reg <= held_reg;
            complete_reg <= !status.move_active;
        end
    end

    assign status.div_done    = div_done;
    assign status.zero_angle  = zero_angle;
    assign status.move_active = (step_count_reg <= {1'b0, total_steps_reg});
    assign status.final_step  = (step_count_reg == {1'b0, total_steps_reg});

    assign setpoint = setpoint_reg;
    assign complete = complete_reg;

`ifndef SYNTH
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_count_reg <= ({1'b0, total_steps_reg} + 1'b1))
        else $error("step count ran past the end of the move");

    a_recip_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_recip_reg != '0) && (step_recip_reg <= ctpt_pkg::RECIP_RESET))
        else $error("step reciprocal out of range");
`endif

endmodule

`default_nettype wire

// File: rtl/ctpt_ctrl.sv
// Controller state machine that sequences move setup, curve evaluation and result handoff.
`default_nettype none

module ctpt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_opcode,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire ctpt_pkg::ctpt_status_t status,
    output ctpt_pkg::ctpt_cmd_t         cmd
);

    ctpt_pkg::ctpt_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ctpt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == ctpt_pkg::OP_START)
                    begin
                        cmd.load_move = 1'b1;
                        state_next    = ctpt_pkg::ST_N_START;
                    end
                    else if (!status.move_active)
                        state_next = ctpt_pkg::ST_OUT;
                    else if (status.final_step)
                    begin
                        cmd.hold_goal = 1'b1;
                        state_next    = ctpt_pkg::ST_OUT;
                    end
                    else
                        state_next = ctpt_pkg::ST_T_MUL;
                end
            end
            ctpt_pkg::ST_N_START:
            begin
                cmd.div_start = !status.zero_angle;
                state_next    = ctpt_pkg::ST_N_WAIT;
            end
            ctpt_pkg::ST_N_WAIT:
            begin
                if (status.zero_angle || status.div_done)
                begin
                    cmd.take_n = 1'b1;
                    state_next = ctpt_pkg::ST_R_START;
                end
            end
            ctpt_pkg::ST_R_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_recip = 1'b1;
                state_next    = ctpt_pkg::ST_R_WAIT;
            end
            ctpt_pkg::ST_R_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.take_r = 1'b1;
                    state_next = ctpt_pkg::ST_IDLE;
                end
            end
            ctpt_pkg::ST_T_MUL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = ctpt_pkg::MUL_T;
                state_next = ctpt_pkg::ST_T2_MUL;
            end
            ctpt_pkg::ST_T2_MUL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = ctpt_pkg::MUL_T2;
                state_next = ctpt_pkg::ST_T3_MUL;
            end
            ctpt_pkg::ST_T3_MUL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = ctpt_pkg::MUL_T3;
                state_next = ctpt_pkg::ST_U_CALC;
            end
            ctpt_pkg::ST_U_CALC:
            begin
                cmd.take_u = 1'b1;
                state_next = ctpt_pkg::ST_ACC_MUL;
            end
            ctpt_pkg::ST_ACC_MUL:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = ctpt_pkg::MUL_ACC;
                state_next = ctpt_pkg::ST_SUM;
            end
            ctpt_pkg::ST_SUM:
            begin
                cmd.take_sum = 1'b1;
                state_next   = ctpt_pkg::ST_OUT;
            end
            ctpt_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ctpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ctpt_pkg::ST_N_WAIT
                             || state_reg == ctpt_pkg::ST_R_WAIT))
        else $error("division finished while the controller was not waiting for it");

    a_load_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result loaded but not presented");
`endif

endmodule

`default_nettype wire

// File: rtl/cubic_point_to_point_trajectory.sv
// Top level of the cubic point-to-point trajectory interpolator.
`default_nettype none

// Cubic point-to-point trajectory interpolator with zero end velocities. A start item
// (opcode 0) loads a move from start_position to goal_position, both signed Q15.16,
// and produces no result. The block then finds the step count N as the move distance
// divided by the step angle, clamped to 1..65535, and a Q1.24 reciprocal of N. Each tick
// item (opcode 1) returns one result item: the setpoint on the cubic curve at the next
// step and a complete flag. The last step returns exactly the target, and once the
// move is complete further ticks return that final position with complete set.
// A start item occupies the block for two passes through a one-bit-per-cycle
// divider of 33 steps each; with a zero step angle the first pass is skipped and N
// is 65535. A tick that evaluates the curve goes through one shared multiplier (step
// times reciprocal, square, cube, then the coefficient product) and a final add with
// saturation; a tick on the last step or after completion skips both. Input items
// are taken one at a time; the result sits in an output register, so the next item
// is accepted while an earlier result still waits. A new result is held in the last
// state until the output register is free. The step angle register resets to 1.0
// and may be written only while the block is idle.
module cubic_point_to_point_trajectory (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write_en,
    input  wire logic [ctpt_pkg::ANGLE_W-1:0]     cfg_write_data,
    ctpt_in_if.sink                               in_chan,
    ctpt_out_if.source                            out_chan
);

    // Command and status buses between the sequencer and the arithmetic.
    ctpt_pkg::ctpt_cmd_t    cmd;
    ctpt_pkg::ctpt_status_t status;

    logic                               in_ready;
    logic                               out_valid;
    logic signed [ctpt_pkg::POS_W-1:0]  setpoint;
    logic                               complete;

    // The controller decides when an item is taken and when a result is presented.
    ctpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_opcode (in_chan.opcode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_chan.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the move, the divider and the multiplier, and the result payload.
    ctpt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .start_position  (in_chan.start_position),
        .goal_position   (in_chan.goal_position),
        .cmd             (cmd),
        .status          (status),
        .setpoint        (setpoint),
        .complete        (complete)
    );

    assign in_chan.ready     = in_ready;
    assign out_chan.valid    = out_valid;
    assign out_chan.setpoint = setpoint;
    assign out_chan.complete = complete;

endmodule

`default_nettype wire

// File: bench/tb_cubic_point_to_point_trajectory.sv
// Self-checking testbench for the cubic point-to-point trajectory interpolator.
`timescale 1ns / 100ps

module tb_cubic_point_to_point_trajectory;

    // The slowest legal run stays far below this cycle count.
    localparam int CYCLE_LIMIT = 1000000;

    // A start item can keep the block busy for two divider passes after it is taken,
    // and it produces no result, so the bench waits SETTLE_CYCLES before touching the
    // step angle register or ending the run.
    localparam int SETTLE_CYCLES = 120;

    localparam longint POS_MAX = 64'sd2147483647;
    localparam longint POS_MIN = -64'sd2147483648;
    localparam longint SPAN_MAX = 64'sd4294967295;

    // One input item as the driver presents it.
    typedef struct {
        ctpt_pkg::ctpt_opcode_t               op;
        logic signed [ctpt_pkg::POS_W-1:0]    from_pos;
        logic signed [ctpt_pkg::POS_W-1:0]    goal_pos;
    } move_item_t;

    // One result item as the block should return it.
    typedef struct {
        logic signed [ctpt_pkg::POS_W-1:0]    setpoint;
        logic                                 complete;
    } setpoint_t;

    logic clk;
    logic rst_n = 1'b1;
    logic cfg_write_en = 1'b0;
    logic [ctpt_pkg::ANGLE_W-1:0] cfg_write_data = '0;

    ctpt_in_if  in_chan ();
    ctpt_out_if out_chan ();

    cubic_point_to_point_trajectory uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_chan        (in_chan),
        .out_chan       (out_chan)
    );

    // Items waiting for the driver, and setpoints waiting for the monitor.
    move_item_t item_queue[$];
    setpoint_t  setpoint_queue[$];

    int mismatch_count = 0;
    int cycle_count = 0;

    // The bench's own copy of the trajectory state. The curve is
    // S(t) = curve_cubic * t^3 + curve_square * t^2 + curve_origin with t in Q0.24.
    longint          model_angle;
    longint          curve_cubic;
    longint          curve_square;
    longint          curve_origin;
    longint          curve_goal;
    longint          move_steps;
    longint          move_recip;
    longint          move_step;
    logic signed [ctpt_pkg::POS_W-1:0] last_setpoint;

    // Driver bookkeeping.
    move_item_t drv_item;
    logic       drv_loaded;
    int         drv_wait;
    int         drv_quiet = 0;

    // Monitor bookkeeping.
    int         mon_wait;
    int         mon_quiet = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Both sides draw a random wait, possibly none, for each item. Now and then a side
    // enters a quiet stretch in which it does not idle at all, so that
    // back-to-back traffic is covered as well.
    task automatic draw_gap(inout int quiet_left, output int gap);
        if (quiet_left > 0)
        begin
            quiet_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            quiet_left = $urandom_range(10, 40);
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 8);
        end
    endtask

    // Evaluates the cubic at the current step. All products fit in 64 bits:
    // t never exceeds 2^24 and the coefficients stay below 2^34.
    function automatic logic signed [ctpt_pkg::POS_W-1:0] curve_point();
        longint t1;
        longint t2;
        longint t3;
        longint acc;
        longint pos;
        t1 = move_step * move_recip;
        t2 = (t1 * t1) >>> ctpt_pkg::RECIP_BITS;
        t3 = (t2 * t1) >>> ctpt_pkg::RECIP_BITS;
        acc = curve_cubic * t3 + curve_square * t2;
        // An arithmetic shift rounds toward minus infinity, as the block does.
        pos = (acc >>> ctpt_pkg::RECIP_BITS) + curve_origin;
        if (pos > POS_MAX)
            pos = POS_MAX;
        if (pos < POS_MIN)
            pos = POS_MIN;
        return pos[ctpt_pkg::POS_W-1:0];
    endfunction

    // Advances the trajectory state for one accepted item and queues the
    // setpoint that a tick should produce.
    task automatic predict_setpoint(input move_item_t it);
        longint    s;
        longint    e;
        longint    diff;
        longint    move_len;
        longint    steps;
        setpoint_t res;
        if (it.op == ctpt_pkg::OP_START)
        begin
            s = longint'(it.from_pos);
            e = longint'(it.goal_pos);
            diff = s - e;
            move_len = (diff < 0) ? -diff : diff;
            // A zero step angle skips the divide and asks for the most steps.
            if (model_angle == 0)
                steps = ctpt_pkg::MAX_STEPS;
            else
                steps = move_len / model_angle;
            if (steps < 1)
                steps = 1;
            if (steps > ctpt_pkg::MAX_STEPS)
                steps = ctpt_pkg::MAX_STEPS;
            curve_cubic = 2 * diff;
            curve_square = -3 * diff;
            curve_origin = s;
            curve_goal = e;
            move_steps = steps;
            move_recip = (64'sd1 <<< ctpt_pkg::RECIP_BITS) / steps;
            move_step = 0;
            last_setpoint = it.from_pos;
        end
        else
        begin
            // Once the move has run past its last step the state is frozen
            // and the final position is repeated.
            if (move_step <= move_steps)
            begin
                if (move_step == move_steps)
                    last_setpoint = curve_goal[ctpt_pkg::POS_W-1:0];
                else
                    last_setpoint = curve_point();
                move_step++;
            end
            res.setpoint = last_setpoint;
            res.complete = (move_step > move_steps);
            setpoint_queue.push_back(res);
        end
    endtask

    // Driver: takes items from the pending queue, waits the drawn gap, then
    // holds valid high until the block takes the item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_chan.valid <= 1'b0;
            in_chan.opcode <= ctpt_pkg::OP_START;
            in_chan.start_position <= '0;
            in_chan.goal_position <= '0;
            drv_loaded = 1'b0;
            drv_wait = 0;
        end
        else
        begin
            if (in_chan.valid && in_chan.ready)
            begin
                predict_setpoint(drv_item);
                drv_loaded = 1'b0;
            end
            if (!drv_loaded && item_queue.size() != 0)
            begin
                drv_item = item_queue.pop_front();
                draw_gap(drv_quiet, drv_wait);
                drv_loaded = 1'b1;
            end
            if (drv_loaded && drv_wait == 0)
            begin
                in_chan.valid <= 1'b1;
                in_chan.opcode <= drv_item.op;
                in_chan.start_position <= drv_item.from_pos;
                in_chan.goal_position <= drv_item.goal_pos;
            end
            else
            begin
                in_chan.valid <= 1'b0;
                if (drv_loaded)
                    drv_wait--;
            end
        end
    end

    // Monitor: checks every accepted result against the oldest expected
    // setpoint, then stalls for a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_chan.ready <= 1'b0;
            mon_wait = 0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                if (setpoint_queue.size() == 0)
                begin
                    report_mismatch($sformatf("result item with no expectation: setpoint %0d",
                                              out_chan.setpoint));
                end
                else
                begin
                    setpoint_t want;
                    want = setpoint_queue.pop_front();
                    if (out_chan.setpoint !== want.setpoint)
                        report_mismatch($sformatf("setpoint %0d, expected %0d",
                                                  out_chan.setpoint, want.setpoint));
                    if (out_chan.complete !== want.complete)
                        report_mismatch($sformatf("complete %b, expected %b",
                                                  out_chan.complete, want.complete));
                end
                draw_gap(mon_quiet, mon_wait);
            end
            if (mon_wait == 0)
            begin
                out_chan.ready <= 1'b1;
            end
            else
            begin
                out_chan.ready <= 1'b0;
                mon_wait--;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, setpoint_queue.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_tick();
        move_item_t it;
        it.op = ctpt_pkg::OP_TICK;
        // Position fields are don't-care on a tick, so they carry noise.
        it.from_pos = $urandom;
        it.goal_pos = $urandom;
        item_queue.push_back(it);
    endtask

    // Queues a start item followed by a number of ticks.
    task automatic push_move(input longint s, input longint e, input int ticks);
        move_item_t it;
        it.op = ctpt_pkg::OP_START;
        it.from_pos = s[ctpt_pkg::POS_W-1:0];
        it.goal_pos = e[ctpt_pkg::POS_W-1:0];
        item_queue.push_back(it);
        repeat (ticks)
            push_tick();
    endtask

    // Blocks until every item has been taken and every setpoint has come back,
    // then lets a trailing start item finish inside the block.
    task automatic wait_drained();
        while (item_queue.size() != 0 || drv_loaded || in_chan.valid
               || setpoint_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Only called while the block is idle, so the model can follow at once.
    task automatic write_angle(input logic [ctpt_pkg::ANGLE_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        model_angle = longint'(value);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cfg_write_data <= ctpt_pkg::ANGLE_W'($urandom);
    endtask

    // Random traffic for one step angle setting. Most of it is complete moves whose
    // distance is a chosen multiple of the step angle plus a smaller rest, so the step
    // count stays small and, with a nonzero angle, each move is ticked through to its
    // end and a little past it. The rest is full-range moves cut short and stray ticks.
    task automatic run_random_phase(input int budget);
        int           added;
        int           sel;
        int           k;
        int           ticks;
        longint       move_len;
        longint       s;
        longint       e;
        longint       tmp;
        longint unsigned rnd;
        added = 0;
        while (added < budget)
        begin
            sel = $urandom_range(0, 7);
            if (sel < 6)
            begin
                k = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60)
                                                : $urandom_range(0, 20);
                move_len = model_angle * k;
                if (model_angle > 0)
                    move_len += longint'({32'd0, $urandom} % model_angle);
                if (move_len > SPAN_MAX)
                    move_len = SPAN_MAX;
                rnd = {$urandom, $urandom};
                s = POS_MIN + longint'(rnd % longint'(SPAN_MAX - move_len + 1));
                e = s + move_len;
                if ($urandom_range(0, 1) == 1)
                begin
                    tmp = s;
                    s = e;
                    e = tmp;
                end
                if (model_angle == 0)
                    ticks = $urandom_range(1, 6);
                else
                    ticks = ((k < 1) ? 1 : k) + 1 + $urandom_range(0, 2);
                push_move(s, e, ticks);
                added += ticks + 1;
            end
            else if (sel == 6)
            begin
                ticks = $urandom_range(0, 4);
                s = longint'($signed($urandom));
                e = longint'($signed($urandom));
                push_move(s, e, ticks);
                added += ticks + 1;
            end
            else
            begin
                ticks = $urandom_range(1, 3);
                repeat (ticks)
                    push_tick();
                added += ticks;
            end
        end
    endtask

    initial
    begin
        logic [ctpt_pkg::ANGLE_W-1:0] angle;
        int                           pick;

        // The model starts in the reset state of the block.
        model_angle = longint'(ctpt_pkg::STEP_ANGLE_RESET);
        curve_cubic = 0;
        curve_square = 0;
        curve_origin = 0;
        curve_goal = 0;
        move_steps = 1;
        move_recip = longint'(ctpt_pkg::RECIP_RESET);
        move_step = longint'(ctpt_pkg::COUNT_RESET);
        last_setpoint = '0;

        // Reset is applied once through a nonblocking write so that every
        // clocked block sees its falling edge.
        rst_n <= 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with the step angle at its reset value of 1.0.
        // A tick straight after reset reports position 0 and a complete move.
        push_tick();
        // Zero distance is clamped to a single step: start, goal, then hold.
        push_move(0, 0, 3);
        // Widest distances in both directions reach the largest step count.
        push_move(POS_MAX, POS_MIN, 3);
        push_move(POS_MIN, POS_MAX, 2);
        // A 3.5 unit move takes three steps; the last step lands exactly on
        // the goal and later ticks repeat it.
        push_move(64'sd5 <<< ctpt_pkg::FRAC_BITS, 64'sd17 <<< (ctpt_pkg::FRAC_BITS - 1), 5);
        // A new start cuts off a move that is still running.
        push_move(0, 64'sd10 <<< ctpt_pkg::FRAC_BITS, 1);
        push_move(-(64'sd2 <<< ctpt_pkg::FRAC_BITS), -(64'sd4 <<< ctpt_pkg::FRAC_BITS), 4);
        wait_drained();

        // Smallest step angle: the full-range moves hit the step limit.
        write_angle(ctpt_pkg::ANGLE_W'(1));
        run_random_phase(150);
        wait_drained();

        // Largest step angle: every move is one or two steps long.
        write_angle({ctpt_pkg::ANGLE_W{1'b1}});
        run_random_phase(150);
        wait_drained();

        // A zero step angle skips the divide; moves are only partly ticked.
        write_angle('0);
        run_random_phase(60);
        wait_drained();

        // Random settings across the whole range, weighted toward values
        // that give short moves with fractional steps.
        repeat (9)
        begin
            pick = $urandom_range(0, 3);
            if (pick == 0)
                angle = ctpt_pkg::ANGLE_W'($urandom_range(1, 32'h0004_0000));
            else if (pick == 1)
                angle = ctpt_pkg::ANGLE_W'($urandom_range(32'h0001_0000, 32'h0100_0000));
            else if (pick == 2)
                angle = ctpt_pkg::ANGLE_W'($urandom);
            else
                angle = ctpt_pkg::STEP_ANGLE_RESET;
            write_angle(angle);
            run_random_phase(115);
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
